// ===== src/bzr_pkg.sv =====
// Shared widths, constants and types of the Bezier point evaluator.
`timescale 1ns / 1ps
package bzr_pkg;

    localparam int COORD_W = 32;
    localparam int TW      = 17;
    // Scaled quintic points reach 29 * 2^31 in magnitude
    localparam int PW      = 37;
    localparam int PRODW   = PW + 1 + TW + 1;
    localparam int NPTS    = 6;
    localparam int NLVL    = NPTS - 1;
    localparam int T_FRAC  = 16;
    localparam int T_HALF  = 32768;

    localparam logic [TW-1:0] T_ONE = TW'(65536);

    // Division by 5 through the reciprocal ceil(2^40 / 5), exact below 2^38
    localparam int DIV_W     = 37;
    localparam int DIV_LO_W  = 19;
    localparam int DIV_HI_W  = DIV_W - DIV_LO_W;
    localparam int DIV_SHIFT = 40;
    localparam int RCP_W     = 38;
    localparam int SUM_W     = DIV_HI_W + RCP_W + DIV_LO_W + 1;
    localparam int QW        = 36;
    localparam logic [RCP_W-1:0] RCP_FIVE = RCP_W'(64'd219902325556);
    // Bias that lifts the shifted value above zero; a multiple of 5
    localparam logic signed [PW:0] DIV_BIAS = (PW + 1)'(64'sd85899345920);
    localparam logic [QW-1:0] QUOT_BIAS = QW'(64'd17179869184);
    localparam logic signed [PW:0] ROUND_20 = (PW + 1)'(10);

    localparam logic signed [PW-1:0] OUT_MAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] OUT_MIN = PW'(-64'sd2147483648);

    typedef logic signed [PW-1:0] pnt_t;
    typedef logic signed [PRODW-1:0] prod_t;

    typedef struct packed {
        logic              quintic;
        logic [TW-1:0]     t;
        pnt_t [NPTS-1:0]   pts;
    } lvl_data_t;

endpackage

// ===== src/bzr_if.sv =====
// Handshake channels of the Bezier point evaluator: sample, point and mode write.
`timescale 1ns / 1ps
interface bzr_in_if;
    logic               valid;
    logic               ready;
    logic [16:0]        param_t;
    logic signed [31:0] start_coord;
    logic signed [31:0] end_coord;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;

    modport source (
        output valid, param_t, start_coord, end_coord, coef_a, coef_b, coef_c, coef_d,
        input  ready
    );
    modport sink (
        input  valid, param_t, start_coord, end_coord, coef_a, coef_b, coef_c, coef_d,
        output ready
    );
endinterface

interface bzr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_coord;
    logic               saturated;

    modport source (output valid, point_coord, saturated, input ready);
    modport sink (input valid, point_coord, saturated, output ready);
endinterface

interface bzr_cfg_if;
    logic valid;
    logic ready;
    logic spline_mode;

    modport source (output valid, spline_mode, input ready);
    modport sink (input valid, spline_mode, output ready);
endinterface

// ===== src/bzr_level.sv =====
// One de Casteljau level: a multiply stage and a round-and-add stage.
`timescale 1ns / 1ps
module bzr_level (
    input  logic              clk,
    input  logic              advance,
    input  logic              cubic_skip,
    input  bzr_pkg::lvl_data_t din,
    output bzr_pkg::lvl_data_t dout
);
    import bzr_pkg::*;

    lvl_data_t            carry_reg;
    prod_t [NPTS-2:0]     prod_reg;
    prod_t [NPTS-2:0]     prod_next;
    lvl_data_t            dout_reg;
    lvl_data_t            dout_next;
    logic signed [PW:0]   diff [NPTS-1];
    prod_t                rnd [NPTS-1];
    logic                 bypass;

    always_comb
    begin
        for (int k = 0; k < NPTS - 1; k++)
        begin
            diff[k] = (PW + 1)'(din.pts[k + 1]) - (PW + 1)'(din.pts[k]);
            prod_next[k] = prod_t'(diff[k]) * prod_t'($signed({1'b0, din.t}));
        end
    end

    // Cubic items sit out the first two levels: four points need three levels
    assign bypass = cubic_skip && !carry_reg.quintic;

    always_comb
    begin
        dout_next = carry_reg;
        for (int k = 0; k < NPTS - 1; k++)
        begin
            rnd[k] = (prod_reg[k] + prod_t'(T_HALF)) >>> T_FRAC;
            if (!bypass)
            begin
                dout_next.pts[k] = carry_reg.pts[k] + rnd[k][PW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            carry_reg <= din;
            prod_reg  <= prod_next;
            dout_reg  <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== src/bezier_segment_point_evaluator.sv =====
// Top level of the cubic and quintic Bezier point evaluator for one axis.
`timescale 1ns / 1ps
// Evaluates one axis of a Bezier segment at t (Q1.16, values above 1 clamp to 1)
// and returns the Q11.20 coordinate, saturated to 32 bits with a flag. The mode
// register picks cubic (start, coef_a, coef_b, end) or quintic (end points,
// tangents coef_a/coef_b, accelerations coef_c/coef_d). The block is a
// 15-stage pipeline that takes one item per cycle while not stalled: an input
// stage forming the scaled control points, five de Casteljau levels of two
// stages each (multiply, then round and add), three stages dividing the
// quintic sum by 20 with a reciprocal multiply, and the saturating output
// register. A stall on the result side holds the whole pipeline in place.
// Write the mode only while the pipeline is empty.
module bezier_segment_point_evaluator (
    input  logic          clk,
    input  logic          rst_n,
    bzr_cfg_if.sink       cfg,
    bzr_in_if.sink        sample,
    bzr_out_if.source     point
);
    import bzr_pkg::*;

    localparam int NSTG = 2 * NLVL + 5;

    logic                  spline_mode_reg;
    logic [NSTG-1:0]       vld_reg;
    logic [NSTG-1:0]       vld_next;
    logic                  advance;

    lvl_data_t             s0_reg;
    lvl_data_t             s0_next;
    lvl_data_t             stage_data [NLVL+1];

    logic [DIV_W-1:0]      u_reg;
    logic [DIV_W-1:0]      u_next;
    pnt_t                  x1_reg;
    logic                  q1_reg;
    logic [DIV_LO_W+RCP_W-1:0] plo_reg;
    logic [DIV_LO_W+RCP_W-1:0] plo_next;
    logic [DIV_HI_W+RCP_W-1:0] phi_reg;
    logic [DIV_HI_W+RCP_W-1:0] phi_next;
    pnt_t                  x2_reg;
    logic                  q2_reg;
    pnt_t                  r_reg;
    pnt_t                  r_next;
    logic signed [COORD_W-1:0] point_reg;
    logic signed [COORD_W-1:0] point_next;
    logic                  sat_reg;
    logic                  sat_next;

    pnt_t                  p0;
    pnt_t                  p5;
    pnt_t                  ca;
    pnt_t                  cb;
    pnt_t                  cc;
    pnt_t                  cd;
    pnt_t                  p0s;
    pnt_t                  p5s;
    logic signed [PW:0]    xr;
    logic signed [PW:0]    xs;
    logic [SUM_W-1:0]      sum;
    logic [QW-1:0]         quot;

    // Mode register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spline_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            spline_mode_reg <= cfg.spline_mode;
        end
    end

    // Pipeline control: one global stall driven by the output register
    assign advance      = !vld_reg[NSTG-1] || point.ready;
    assign sample.ready = advance;
    assign vld_next     = {vld_reg[NSTG-2:0], sample.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    // Input stage: form the scaled control points
    always_comb
    begin
        p0  = pnt_t'(sample.start_coord);
        p5  = pnt_t'(sample.end_coord);
        ca  = pnt_t'(sample.coef_a);
        cb  = pnt_t'(sample.coef_b);
        cc  = pnt_t'(sample.coef_c);
        cd  = pnt_t'(sample.coef_d);
        p0s = (p0 <<< 4) + (p0 <<< 2);
        p5s = (p5 <<< 4) + (p5 <<< 2);

        s0_next.quintic = spline_mode_reg;
        s0_next.t       = (sample.param_t > T_ONE) ? T_ONE : sample.param_t;
        if (spline_mode_reg)
        begin
            s0_next.pts[0] = p0s;
            s0_next.pts[1] = p0s + (ca <<< 2);
            s0_next.pts[2] = p0s + (ca <<< 3) + cc;
            s0_next.pts[3] = p5s - (cb <<< 3) + cd;
            s0_next.pts[4] = p5s - (cb <<< 2);
            s0_next.pts[5] = p5s;
        end
        else
        begin
            // Cubic points go to the first four slots (0 to 3); the levels that
            // they skip leave them untouched
            s0_next.pts[0] = p0;
            s0_next.pts[1] = ca;
            s0_next.pts[2] = cb;
            s0_next.pts[3] = p5;
            s0_next.pts[4] = '0;
            s0_next.pts[5] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg <= s0_next;
        end
    end

    assign stage_data[0] = s0_reg;

    for (genvar g = 0; g < NLVL; g++)
    begin : g_lvl
        bzr_level u_level (
            .clk        (clk),
            .advance    (advance),
            .cubic_skip ((g < 2) ? 1'b1 : 1'b0),
            .din        (stage_data[g]),
            .dout       (stage_data[g + 1])
        );
    end

    // Quintic result is floor((x + 10) / 20): shift right by 2, then divide by 5
    always_comb
    begin
        xr     = (PW + 1)'(stage_data[NLVL].pts[0]) + ROUND_20;
        xs     = (xr >>> 2) + DIV_BIAS;
        u_next = xs[DIV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            u_reg  <= u_next;
            x1_reg <= stage_data[NLVL].pts[0];
            q1_reg <= stage_data[NLVL].quintic;
        end
    end

    assign plo_next = (DIV_LO_W + RCP_W)'(u_reg[DIV_LO_W-1:0])
                    * (DIV_LO_W + RCP_W)'(RCP_FIVE);
    assign phi_next = (DIV_HI_W + RCP_W)'(u_reg[DIV_W-1:DIV_LO_W])
                    * (DIV_HI_W + RCP_W)'(RCP_FIVE);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            x2_reg  <= x1_reg;
            q2_reg  <= q1_reg;
        end
    end

    always_comb
    begin
        sum  = {1'b0, phi_reg, {DIV_LO_W{1'b0}}} + SUM_W'(plo_reg);
        quot = sum[DIV_SHIFT+QW-1:DIV_SHIFT] - QUOT_BIAS;
        r_next = q2_reg ? pnt_t'($signed(quot)) : x2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_reg <= r_next;
        end
    end

    // Output stage: clip to 32 bits
    always_comb
    begin
        if (r_reg > OUT_MAX)
        begin
            point_next = OUT_MAX[COORD_W-1:0];
            sat_next   = 1'b1;
        end
        else if (r_reg < OUT_MIN)
        begin
            point_next = OUT_MIN[COORD_W-1:0];
            sat_next   = 1'b1;
        end
        else
        begin
            point_next = r_reg[COORD_W-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            point_reg <= point_next;
            sat_reg   <= sat_next;
        end
    end

    assign point.valid       = vld_reg[NSTG-1];
    assign point.point_coord = point_reg;
    assign point.saturated   = sat_reg;

endmodule

// ===== sim/tb.sv =====
// Testbench for the Bezier segment point evaluator, with a scoreboard that predicts each point.
`timescale 1ns / 1ps
module tb;
    import bzr_pkg::*;

    localparam int  DRAIN_CYCLES = 20;
    localparam int  MAX_REPORTS  = 10;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

    typedef enum logic {MODE_CUBIC = 1'b0, MODE_QUINTIC = 1'b1} spline_mode_e;

    typedef struct {
        logic [TW-1:0]      param_t;
        logic signed [31:0] start_coord;
        logic signed [31:0] end_coord;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
    } sample_t;

    typedef struct {
        logic signed [31:0] coord;
        logic               sat;
    } point_t;

    class curve_point_checker;
        spline_mode_e mode;
        point_t       pending_points[$];
        int           n_cubic;
        int           n_quintic;
        int           n_sat;
        int           n_errors;

        function new();
            mode      = MODE_CUBIC;
            n_cubic   = 0;
            n_quintic = 0;
            n_sat     = 0;
            n_errors  = 0;
        endfunction

        // Work out the curve point for an accepted sample and queue it
        function void note_sample(sample_t s);
            longint pts[NPTS];
            longint t;
            longint scale;
            longint num;
            longint r;
            int     top;
            point_t p;
            t = longint'(s.param_t);
            if (t > longint'(T_ONE))
                t = longint'(T_ONE);
            if (mode == MODE_QUINTIC)
            begin
                scale  = 20;
                top    = 5;
                pts[0] = 20 * longint'(s.start_coord);
                pts[1] = pts[0] + 4 * longint'(s.coef_a);
                pts[2] = pts[0] + 8 * longint'(s.coef_a) + longint'(s.coef_c);
                pts[5] = 20 * longint'(s.end_coord);
                pts[4] = pts[5] - 4 * longint'(s.coef_b);
                pts[3] = pts[5] - 8 * longint'(s.coef_b) + longint'(s.coef_d);
                n_quintic++;
            end
            else
            begin
                scale  = 1;
                top    = 3;
                pts[0] = longint'(s.start_coord);
                pts[1] = longint'(s.coef_a);
                pts[2] = longint'(s.coef_b);
                pts[3] = longint'(s.end_coord);
                pts[4] = 0;
                pts[5] = 0;
                n_cubic++;
            end
            // de Casteljau, each step rounded to nearest with ties upward
            for (int lvl = top; lvl > 0; lvl--)
                for (int k = 0; k < lvl; k++)
                    pts[k] = pts[k] + (((pts[k + 1] - pts[k]) * t + T_HALF) >>> T_FRAC);
            num = 2 * pts[0] + scale;
            r   = num / (2 * scale);
            if ((num % (2 * scale)) != 0 && num < 0)
                r--;
            p.sat = 1'b0;
            if (r > longint'(OUT_MAX))
            begin
                r     = longint'(OUT_MAX);
                p.sat = 1'b1;
            end
            else if (r < longint'(OUT_MIN))
            begin
                r     = longint'(OUT_MIN);
                p.sat = 1'b1;
            end
            p.coord = r[31:0];
            pending_points = {pending_points, p};
        endfunction

        function void check_point(logic signed [31:0] coord, logic sat);
            point_t e;
            if (pending_points.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("tb: unexpected point coord=%0d sat=%0b at %0t", coord, sat, $realtime);
                return;
            end
            e = pending_points.pop_front();
            if (e.coord !== coord || e.sat !== sat)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("tb: point mismatch at %0t: expected coord=%0d sat=%0b, got coord=%0d sat=%0b",
                             $realtime, e.coord, e.sat, coord, sat);
            end
            else if (sat)
                n_sat++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   n_mode_writes;
    curve_point_checker sb;

    bzr_cfg_if cfg_if ();
    bzr_in_if  sample_if ();
    bzr_out_if point_if ();

    bezier_segment_point_evaluator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .sample (sample_if),
        .point  (point_if)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = C_MAX;
            1: v = C_MIN;
            2: v = 32'($urandom_range(0, 2)) - 32'sd1;
            3, 4, 5: v = $urandom;
            default: v = 32'($urandom_range(0, 32'd33554432)) - 32'sd16777216;
        endcase
        return v;
    endfunction

    function automatic sample_t make_sample(logic [TW-1:0] t, logic signed [31:0] p0,
                                            logic signed [31:0] p5, logic signed [31:0] a,
                                            logic signed [31:0] b, logic signed [31:0] c,
                                            logic signed [31:0] d);
        sample_t s;
        s.param_t     = t;
        s.start_coord = p0;
        s.end_coord   = p5;
        s.coef_a      = a;
        s.coef_b      = b;
        s.coef_c      = c;
        s.coef_d      = d;
        return s;
    endfunction

    function automatic sample_t rand_sample();
        logic [TW-1:0] t;
        case ($urandom_range(0, 9))
            0: t = '0;
            1: t = T_ONE;
            2: t = TW'($urandom_range(65537, 131071));
            default: t = TW'($urandom_range(0, 65536));
        endcase
        return make_sample(t, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord());
    endfunction

    // Enter and leave at a falling edge; valid stays high for a following item
    task automatic drive_sample(sample_t s);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid       <= 1'b1;
        sample_if.param_t     <= s.param_t;
        sample_if.start_coord <= s.start_coord;
        sample_if.end_coord   <= s.end_coord;
        sample_if.coef_a      <= s.coef_a;
        sample_if.coef_b      <= s.coef_b;
        sample_if.coef_c      <= s.coef_c;
        sample_if.coef_d      <= s.coef_d;
        do
            @(posedge clk);
        while (!sample_if.ready);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    // Hold off until the pipeline is empty, then write the mode
    task automatic write_mode(spline_mode_e m);
        sample_if.valid <= 1'b0;
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.spline_mode <= m;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.mode = m;
        n_mode_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random(spline_mode_e m, int n);
        write_mode(m);
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            drive_sample(rand_sample());
        end
        no_idle = 1'b0;
    endtask

    // Result side: stall at random, with bursts of steady ready
    initial
    begin
        int stall;
        point_if.ready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = gap_len();
            if (stall > 0)
            begin
                point_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            point_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && point_if.valid && point_if.ready)
            sb.check_point(point_if.point_coord, point_if.saturated);
    end

    initial
    begin
        sb                    = new();
        no_idle               = 1'b0;
        n_mode_writes         = 0;
        rst_n                 <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.spline_mode    <= 1'b0;
        sample_if.valid       <= 1'b0;
        sample_if.param_t     <= '0;
        sample_if.start_coord <= '0;
        sample_if.end_coord   <= '0;
        sample_if.coef_a      <= '0;
        sample_if.coef_b      <= '0;
        sample_if.coef_c      <= '0;
        sample_if.coef_d      <= '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Cubic out of reset: t at the ends, t above one, ignored accelerations
        drive_sample(make_sample(0, C_MAX, C_MIN, C_MAX, C_MIN, 0, 0));
        drive_sample(make_sample(T_ONE, C_MAX, C_MIN, C_MAX, C_MIN, 0, 0));
        drive_sample(make_sample(17'h1FFFF, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN));
        drive_sample(make_sample(65537, 1, -1, 3, -3, C_MIN, C_MAX));
        drive_sample(make_sample(32768, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
        drive_sample(make_sample(1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        drive_sample(make_sample(65535, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        drive_sample(make_sample(21845, 0, 32'sd3145728, 32'sd1048576, -32'sd1048576, 0, 0));
        drive_sample(make_sample(32768, -1, 1, -1, 1, 0, 0));

        // Quintic: overshoot past both rails, tangents alone, accelerations alone
        write_mode(MODE_QUINTIC);
        drive_sample(make_sample(32768, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX));
        drive_sample(make_sample(8192, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        drive_sample(make_sample(57344, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN));
        drive_sample(make_sample(0, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX));
        drive_sample(make_sample(T_ONE, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN));
        drive_sample(make_sample(17'h1FFFF, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX));
        drive_sample(make_sample(16384, 0, 0, C_MAX, C_MIN, 0, 0));
        drive_sample(make_sample(49152, 0, 0, 0, 0, C_MAX, C_MIN));
        drive_sample(make_sample(32768, -1, 1, 3, -3, 1, -1));
        drive_sample(make_sample(1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));

        run_random(MODE_CUBIC, 280);
        run_random(MODE_QUINTIC, 300);
        run_random(MODE_CUBIC, 260);
        run_random(MODE_QUINTIC, 300);

        sample_if.valid <= 1'b0;
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_points.size() != 0)
        begin
            sb.n_errors++;
            $display("tb: %0d points never arrived", sb.pending_points.size());
        end

        $display("tb: %0d samples checked, %0d cubic and %0d quintic, over %0d mode writes",
                 sb.n_cubic + sb.n_quintic, sb.n_cubic, sb.n_quintic, n_mode_writes);
        $display("tb: %0d saturated points seen, %0d errors", sb.n_sat, sb.n_errors);
        if (sb.n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
